// File: rtl/wtosc_pkg.sv
package wtosc_pkg;

  localparam int ADDR_BITS  = 12;
  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 4;
  localparam int BITS_W     = 5;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int BITS_LIMIT = (ADDR_BITS > 16) ? 16 : ADDR_BITS;

  typedef enum logic [1:0] {
    CMD_GEN   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RESET = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LEN  = 1'd1;

  localparam logic [LEN_W-1:0] WAVE_LEN_RST = 4'd8;

  // one stage-1 item as seen by the wave memory
  typedef struct packed {
    logic                 wr;
    logic                 rd;
    logic [PHASE_W-1:0]   phase;
    logic [BITS_W-1:0]    bits;
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_W-1:0]    data;
  } mem_req_t;

  // active index bits, clamped to 1..BITS_LIMIT
  function automatic logic [BITS_W-1:0] active_bits(input logic [LEN_W-1:0] len);
    logic [BITS_W-1:0] b;
    b = {1'b0, len};
    if (b == '0) b = BITS_W'(1);
    if (b > BITS_W'(BITS_LIMIT)) b = BITS_W'(BITS_LIMIT);
    return b;
  endfunction

  // b*65534/255 - 32767 == 257*b - (b != 0) - 32767 for any byte
  function automatic logic signed [SAMPLE_W-1:0] byte_to_level(input logic [BYTE_W-1:0] b);
    logic [SAMPLE_W:0] lvl;
    lvl = {1'b0, b, b} - (SAMPLE_W+1)'(b != '0) - (SAMPLE_W+1)'(32767);
    return lvl[SAMPLE_W-1:0];
  endfunction

endpackage

// File: rtl/wavetable_oscillator_sync_interp_unit.sv
// Wavetable oscillator with linear interpolation.
// Input channel (in_valid/in_ready) carries commands: generate one sample,
// write one byte of wave memory, or clear the phase. Only generate commands
// give a result on the output channel (out_valid/out_ready): a signed 16-bit
// sample and a sync flag that marks a phase wrap or a forced sync.
// Configuration (cfg_we/cfg_index/cfg_data) sets the phase increment and the
// log2 wave length; write it only while no items are in flight.
// Throughput: one item per cycle while in_ready is high. The only loop between items is the 32-bit
// phase add, done at the input transfer.
// A generate result passes through the phase, memory read, level conversion,
// multiply and output registers after its input transfer.
// A wave byte written by one item is seen by every later generate item.
// Reset clears the phase, the increment (0), sets the log2 wave length to 8 and
// empties the pipeline; wave memory is not cleared and must be loaded first.
// When the receiver stalls, results pile into free pipeline stages; in_ready
// drops only once every stage up to the output register holds an item.
module wavetable_oscillator_sync_interp_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_cmd,
  input  logic                                    in_sync_in,
  input  logic [wtosc_pkg::ADDR_BITS-1:0]         in_wave_address,
  input  logic [wtosc_pkg::BYTE_W-1:0]            in_wave_byte,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0]   out_audio_sample,
  output logic                                    out_sync_out,
  input  logic                                    cfg_we,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wtosc_pkg::CFG_W-1:0]             cfg_data
);

  localparam int SW = wtosc_pkg::SAMPLE_W;

  logic [wtosc_pkg::PHASE_W-1:0]   phase_inc_r;
  logic [wtosc_pkg::LEN_W-1:0]     wave_len_r;
  logic [wtosc_pkg::PHASE_W-1:0]   phase_r;
  logic [wtosc_pkg::PHASE_W-1:0]   phase_sum;
  logic [wtosc_pkg::PHASE_W-1:0]   phase_nxt;
  logic                            wrap_nxt;

  logic                            s1_valid_r;
  logic                            s1_gen_r;
  logic [wtosc_pkg::PHASE_W-1:0]   s1_phase_r;
  logic                            s1_wrap_r;
  logic [wtosc_pkg::BITS_W-1:0]    s1_bits_r;
  logic [wtosc_pkg::ADDR_BITS-1:0] s1_addr_r;
  logic [wtosc_pkg::BYTE_W-1:0]    s1_byte_r;

  logic                            s2_valid_r;
  logic                            s2_wrap_r;
  logic [wtosc_pkg::BYTE_W-1:0]    lo_byte;
  logic [wtosc_pkg::BYTE_W-1:0]    hi_byte;
  logic [wtosc_pkg::FRAC_W-1:0]    weight;

  logic                            s3_valid_r;
  logic                            s3_wrap_r;
  logic signed [SW-1:0]            s3_base_r;
  logic signed [SW:0]              s3_diff_r;
  logic [wtosc_pkg::FRAC_W-1:0]    s3_weight_r;

  logic                            s4_valid_r;
  logic                            s4_wrap_r;
  logic signed [SW-1:0]            s4_base_r;
  logic signed [2*SW+1:0]          s4_prod_r;
  logic signed [2*SW+1:0]          prod;

  logic                            out_valid_r;
  logic signed [SW-1:0]            out_sample_r;
  logic                            out_sync_r;
  logic signed [SW-1:0]            sample_nxt;

  logic signed [SW-1:0]            lvl_lo;
  logic signed [SW-1:0]            lvl_hi;

  logic                            out_free;
  logic                            s4_free;
  logic                            s3_free;
  logic                            s2_free;
  logic                            s1_free;
  logic                            in_xfer;
  logic                            in_gen;
  logic                            in_wr;

  wtosc_pkg::mem_req_t             mem_req;

  // per-stage flow control: a stage loads when it is empty or drains
  always_comb begin
    out_free = !out_valid_r || out_ready;
    s4_free  = !s4_valid_r || out_free;
    s3_free  = !s3_valid_r || s4_free;
    s2_free  = !s2_valid_r || s3_free;
    s1_free  = !s1_valid_r || s2_free;
    in_ready = s1_free;
    in_xfer  = in_valid && in_ready;
    in_gen   = (in_cmd == wtosc_pkg::CMD_GEN);
    in_wr    = (in_cmd == wtosc_pkg::CMD_WRITE);
  end

  always_comb begin
    phase_sum = phase_r + phase_inc_r;
    phase_nxt = in_sync_in ? '0 : phase_sum;
    wrap_nxt  = in_sync_in || (phase_sum < phase_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      wave_len_r  <= wtosc_pkg::WAVE_LEN_RST;
      phase_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wtosc_pkg::CFG_PHASE_INC: phase_inc_r <= cfg_data;
          wtosc_pkg::CFG_WAVE_LEN:  wave_len_r  <= cfg_data[wtosc_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        case (in_cmd)
          wtosc_pkg::CMD_GEN:   phase_r <= phase_nxt;
          wtosc_pkg::CMD_RESET: phase_r <= '0;
          default: ;
        endcase
      end
    end
  end

  // stage 1: phase result and write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_xfer && (in_gen || in_wr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_gen_r   <= in_gen;
      s1_phase_r <= phase_nxt;
      s1_wrap_r  <= wrap_nxt;
      s1_bits_r  <= wtosc_pkg::active_bits(wave_len_r);
      s1_addr_r  <= in_wave_address;
      s1_byte_r  <= in_wave_byte;
    end
  end

  // stage 2: wave memory write or two-entry read
  always_comb begin
    mem_req.wr    = s1_valid_r && !s1_gen_r;
    mem_req.rd    = s1_valid_r && s1_gen_r;
    mem_req.phase = s1_phase_r;
    mem_req.bits  = s1_bits_r;
    mem_req.addr  = s1_addr_r;
    mem_req.data  = s1_byte_r;
  end

  wtosc_wave_mem u_wave_mem (
    .clk       (clk),
    .en        (s2_free),
    .req       (mem_req),
    .lo_byte_r (lo_byte),
    .hi_byte_r (hi_byte),
    .weight_r  (weight)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r && s1_gen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r && s1_gen_r) begin
      s2_wrap_r <= s1_wrap_r;
    end
  end

  // stage 3: bytes to levels, interpolation as base + diff * weight
  always_comb begin
    lvl_lo = wtosc_pkg::byte_to_level(lo_byte);
    lvl_hi = wtosc_pkg::byte_to_level(hi_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_free) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid_r) begin
      s3_wrap_r   <= s2_wrap_r;
      s3_base_r   <= lvl_lo;
      s3_diff_r   <= (SW+1)'(lvl_hi) - (SW+1)'(lvl_lo);
      s3_weight_r <= weight;
    end
  end

  // stage 4: multiply
  assign prod = s3_diff_r * $signed({1'b0, s3_weight_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_free) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free && s3_valid_r) begin
      s4_wrap_r <= s3_wrap_r;
      s4_base_r <= s3_base_r;
      s4_prod_r <= prod;
    end
  end

  // arithmetic shift by the fraction width; result always fits 16 bits
  assign sample_nxt = s4_base_r + s4_prod_r[SW+wtosc_pkg::FRAC_W-1:wtosc_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s4_valid_r) begin
      out_sample_r <= sample_nxt;
      out_sync_r   <= s4_wrap_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_audio_sample = out_sample_r;
  assign out_sync_out     = out_sync_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && s1_valid_r && s2_valid_r
                   && s3_valid_r && s4_valid_r))
    else $error("input stalled while pipeline has a free stage");

  a_sync_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_gen && in_sync_in) |=> (phase_r == '0))
    else $error("sync did not clear phase");

  a_reset_cmd_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_cmd == wtosc_pkg::CMD_RESET)) |=> (phase_r == '0))
    else $error("reset command did not clear phase");

  a_gen_reaches_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_gen_r && s2_free) |=> s2_valid_r)
    else $error("generate item lost between stage 1 and stage 2");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_gen_r && s2_free) |=> !s2_valid_r)
    else $error("write item entered the result path");
`endif

endmodule

// File: rtl/wtosc_wave_mem.sv
module wtosc_wave_mem (
  input  logic                                   clk,
  input  logic                                   en,
  input  wtosc_pkg::mem_req_t                    req,
  output logic [wtosc_pkg::BYTE_W-1:0]           lo_byte_r,
  output logic [wtosc_pkg::BYTE_W-1:0]           hi_byte_r,
  output logic [wtosc_pkg::FRAC_W-1:0]           weight_r
);

  localparam int DEPTH = 1 << wtosc_pkg::ADDR_BITS;

  logic [wtosc_pkg::BYTE_W-1:0]    mem [DEPTH];

  logic [5:0]                      idx_sh;
  logic [5:0]                      frac_sh;
  logic [wtosc_pkg::PHASE_W-1:0]   lo_full;
  logic [wtosc_pkg::PHASE_W-1:0]   weight_full;
  logic [wtosc_pkg::ADDR_BITS-1:0] mask;
  logic [wtosc_pkg::ADDR_BITS-1:0] lo_idx;
  logic [wtosc_pkg::ADDR_BITS-1:0] hi_idx;

  always_comb begin
    idx_sh      = 6'(wtosc_pkg::PHASE_W) - 6'(req.bits);
    frac_sh     = 6'(wtosc_pkg::FRAC_W) - 6'(req.bits);
    lo_full     = req.phase >> idx_sh;
    weight_full = req.phase >> frac_sh;
    mask        = ~({wtosc_pkg::ADDR_BITS{1'b1}} << req.bits);
    lo_idx      = lo_full[wtosc_pkg::ADDR_BITS-1:0];
    // neighbor wraps to entry 0 after the last active entry
    hi_idx      = (lo_idx + wtosc_pkg::ADDR_BITS'(1)) & mask;
  end

  always_ff @(posedge clk) begin
    if (en && req.wr) begin
      mem[req.addr] <= req.data;
    end
    if (en && req.rd) begin
      lo_byte_r <= mem[lo_idx];
      hi_byte_r <= mem[hi_idx];
      weight_r  <= weight_full[wtosc_pkg::FRAC_W-1:0];
    end
  end

endmodule
